/* hdl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the binned bump allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BINS_DEF        = 32;
  localparam int BIN_SIZE_LOG2_DEF   = 22;
  localparam int ENTRIES_PER_BIN_DEF = 256;
  localparam int BLOCK_BYTES_DEF     = 16;

  localparam int LEN_W  = 22;
  localparam int ADDR_W = 27;
  localparam int ST_W   = 3;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_EXHAUSTED  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TOO_LARGE  = 3'd4
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] result_address;
  } out_item_t;

  // compare unit controls from the sequencer
  typedef struct packed {
    logic is_free;
    logic ent_used;
  } cmp_ctl_t;

endpackage

/* hdl/bba_cmp.sv */
// ----------------------------------------------------------------------------
// bba_cmp
// Shared entry compare unit: fit test for allocate, range test for free.
// ----------------------------------------------------------------------------
module bba_cmp
  import bba_pkg::*;
#(
  parameter int OFF_W = BIN_SIZE_LOG2_DEF + 1,
  parameter int GW    = 33
) (
  input  cmp_ctl_t         ctl,
  input  logic [GW-1:0]    base,
  input  logic [OFF_W-1:0] ent_start,
  input  logic [OFF_W-1:0] ent_size,
  input  logic [OFF_W-1:0] req_size,
  input  logic [GW-1:0]    req_addr,
  output logic             hit
);
  logic [GW-1:0] lo;
  logic [GW-1:0] hi;

  // entry bounds and match
  always_comb begin
    lo = base + GW'(ent_start);
    hi = lo + GW'(ent_size);
    if (ctl.is_free) begin
      hit = ctl.ent_used && (req_addr >= lo) && (req_addr < hi);
    end else begin
      hit = !ctl.ent_used && (req_size <= ent_size);
    end
  end
endmodule

/* hdl/binned_bump_allocator.sv */
// ----------------------------------------------------------------------------
// binned_bump_allocator
// Binned bump allocator with first-fit reuse of freed chunks.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall/in_data: allocate (length) or free
// (address). Each request gives exactly one transfer on out_valid/out_stall/
// out_data with a status and, for a good allocate, the global address.
// One request is handled at a time; in_stall is high while it is at work.
// An allocate walks the active bin's entries through the entry memory read
// port and the shared compare unit; each entry is read, then compared.
// A free walks bins 0 up to the active bin and their entries in the same
// way, stepping to the next bin once a bin's counted entries are done.
// Reset clears the active bin and all per-bin fill offsets and counts; the
// entry memory needs no clearing since only counted entries are read.
// The result sits in an output register; while out_stall is high it holds
// and no new request is taken until it has been transferred.
// ----------------------------------------------------------------------------
module binned_bump_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BINS        = NUM_BINS_DEF,
  parameter int BIN_SIZE_LOG2   = BIN_SIZE_LOG2_DEF,
  parameter int ENTRIES_PER_BIN = ENTRIES_PER_BIN_DEF,
  parameter int BLOCK_BYTES     = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam int BW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int EW    = (ENTRIES_PER_BIN > 1) ? $clog2(ENTRIES_PER_BIN) : 1;
  localparam int CW    = $clog2(ENTRIES_PER_BIN + 1);
  localparam int OFF_W = BIN_SIZE_LOG2 + 1;
  localparam int GW    = BIN_SIZE_LOG2 + BW + 2;
  localparam int MW    = BW + EW;
  localparam int SW    = (LEN_W + 1 > OFF_W) ? LEN_W + 1 : OFF_W;
  localparam int BLW   = $clog2(BLOCK_BYTES);
  localparam logic [SW-1:0] BIN_BYTES = SW'(1) << BIN_SIZE_LOG2;
  localparam logic [SW-1:0] BLK       = SW'(BLOCK_BYTES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOVE  = 7'b0000010,
    S_ARD   = 7'b0000100,
    S_ACMP  = 7'b0001000,
    S_FBIN  = 7'b0010000,
    S_FCMP  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [BW-1:0]    active_r, active_nxt;
  logic [OFF_W-1:0] fill_r  [NUM_BINS];
  logic [CW-1:0]    count_r [NUM_BINS];

  logic [2*OFF_W:0] mem [NUM_BINS << EW];
  logic [2*OFF_W:0] rd_r;

  logic [BW-1:0]    bin_r, bin_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [OFF_W-1:0] size_r, size_nxt;
  logic [GW-1:0]    addr_r, addr_nxt;
  logic             is_free_r, is_free_nxt;
  out_item_t        out_r, out_nxt;

  logic             wr_en;
  logic [MW-1:0]    wr_a;
  logic [2*OFF_W:0] wr_d;
  logic [MW-1:0]    rd_a;
  logic [MW-1:0]    last_a_r;
  logic             fill_we, count_we;
  logic [BW-1:0]    upd_bin;
  logic [OFF_W-1:0] fill_d;
  logic [CW-1:0]    count_d;

  logic [SW-1:0]    sum;
  logic [SW-1:0]    req_sz;
  logic [OFF_W-1:0] ent_start, ent_size;
  logic             ent_used;
  logic             hit;
  logic [GW-1:0]    base;
  cmp_ctl_t         cctl;

  // size: length plus one block, rounded down
  always_comb begin
    sum    = SW'(in_data.length) + BLK;
    req_sz = (sum >> BLW) << BLW;
  end

  assign ent_used  = rd_r[2*OFF_W];
  assign ent_start = rd_r[2*OFF_W-1:OFF_W];
  assign ent_size  = rd_r[OFF_W-1:0];
  assign base      = GW'(bin_r) << BIN_SIZE_LOG2;
  assign cctl      = '{is_free: is_free_r, ent_used: ent_used};

  bba_cmp #(.OFF_W(OFF_W), .GW(GW)) u_cmp (
    .ctl      (cctl),
    .base     (base),
    .ent_start(ent_start),
    .ent_size (ent_size),
    .req_size (size_r),
    .req_addr (addr_r),
    .hit      (hit)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    bin_nxt     = bin_r;
    idx_nxt     = idx_r;
    n_nxt       = n_r;
    size_nxt    = size_r;
    addr_nxt    = addr_r;
    is_free_nxt = is_free_r;
    out_nxt     = out_r;
    wr_en       = 1'b0;
    wr_a        = last_a_r;
    wr_d        = rd_r;
    fill_we     = 1'b0;
    count_we    = 1'b0;
    upd_bin     = bin_r;
    fill_d      = fill_r[bin_r];
    count_d     = count_r[bin_r];
    rd_a        = {bin_r, idx_r[EW-1:0]};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_free_nxt = in_data.operation;
          addr_nxt    = GW'(in_data.address);
          size_nxt    = OFF_W'(req_sz);
          out_nxt     = '{status: ST_OK, result_address: '0};
          idx_nxt     = '0;
          if (in_data.operation == OP_FREE) begin
            bin_nxt   = '0;
            state_nxt = S_FBIN;
          end else if (req_sz >= BIN_BYTES) begin
            out_nxt.status = ST_TOO_LARGE;
            state_nxt      = S_OUT;
          end else begin
            bin_nxt   = active_r;
            state_nxt = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        if (SW'(fill_r[bin_r]) + SW'(size_r) >= BIN_BYTES) begin
          if (32'(bin_r) + 1 > NUM_BINS - 1) begin
            out_nxt.status = ST_EXHAUSTED;
            state_nxt      = S_OUT;
          end else begin
            bin_nxt    = bin_r + BW'(1);
            active_nxt = bin_r + BW'(1);
            upd_bin    = bin_r + BW'(1);
            fill_we    = 1'b1;
            count_we   = 1'b1;
            fill_d     = '0;
            count_d    = '0;
            n_nxt      = '0;
            state_nxt  = S_ARD;
          end
        end else begin
          n_nxt     = count_r[bin_r];
          state_nxt = S_ARD;
        end
      end
      S_ARD: begin
        if (idx_r >= n_r) begin
          if (32'(n_r) >= ENTRIES_PER_BIN) begin
            out_nxt.status = ST_TABLE_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_a     = {bin_r, idx_r[EW-1:0]};
            wr_d     = {1'b1, fill_r[bin_r], size_r};
            fill_we  = 1'b1;
            count_we = 1'b1;
            fill_d   = fill_r[bin_r] + size_r;
            count_d  = n_r + CW'(1);
            out_nxt.result_address = ADDR_W'(base + GW'(fill_r[bin_r]));
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ACMP;
        end
      end
      S_ACMP: begin
        if (hit) begin
          wr_en = 1'b1;
          wr_d  = {1'b1, ent_start, ent_size};
          out_nxt.result_address = ADDR_W'(base + GW'(ent_start));
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_ARD;
        end
      end
      S_FBIN: begin
        rd_a  = {bin_r, idx_r[EW-1:0]};
        n_nxt = count_r[bin_r];
        if (idx_r >= count_r[bin_r]) begin
          if (bin_r >= active_r) begin
            out_nxt.status = ST_NOT_FOUND;
            state_nxt      = S_OUT;
          end else begin
            bin_nxt = bin_r + BW'(1);
            idx_nxt = '0;
          end
        end else begin
          state_nxt = S_FCMP;
        end
      end
      S_FCMP: begin
        if (hit) begin
          wr_en     = 1'b1;
          wr_d      = {1'b0, ent_start, ent_size};
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_FBIN;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // entry memory, one port each way
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_r     <= mem[rd_a];
    last_a_r <= rd_a;
  end

  // control and per-bin state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        fill_r[b]  <= '0;
        count_r[b] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      if (fill_we)  fill_r[upd_bin]  <= fill_d;
      if (count_we) count_r[upd_bin] <= count_d;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    idx_r     <= idx_nxt;
    n_r       <= n_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    is_free_r <= is_free_nxt;
    out_r     <= out_nxt;
  end
endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binned bump allocator.
// ----------------------------------------------------------------------------
// Requests are generated up front and run through a behavioural model of the
// bin and entry tables, which yields the expected status and address of
// every request. A clocked driver feeds the requests with random gaps, and a
// clocked monitor checks each result transfer against the oldest expectation
// while out_stall is toggled at random.
// ----------------------------------------------------------------------------
module testbench
  import bba_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS     = NUM_BINS_DEF;
  localparam int NENT      = ENTRIES_PER_BIN_DEF;
  localparam int BLK       = BLOCK_BYTES_DEF;
  localparam longint BINB  = longint'(1) << BIN_SIZE_LOG2_DEF;
  localparam int LIMIT     = 40000000;
  localparam int NOIDLE_LO = 3000;
  localparam int NOIDLE_HI = 12000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // model state of the allocator
  int     cur_bin;
  longint fill_off [NBINS];
  int     ent_count [NBINS];
  longint ent_start [NBINS][NENT];
  longint ent_size [NBINS][NENT];
  bit     ent_used [NBINS][NENT];

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  longint    handed_out[$];
  int        cycles = 0;
  int        mismatches = 0;
  bit        all_done = 1'b0;

  always #5 clk = ~clk;

  binned_bump_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // allocate: bin move, first-fit reuse, else bump
  function automatic out_item_t model_alloc(longint len);
    out_item_t r;
    longint    sz;
    int        b;
    int        n;
    r = '0;
    sz = ((len + BLK) / BLK) * BLK;
    if (sz >= BINB) begin
      r.status = ST_TOO_LARGE;
      return r;
    end
    b = cur_bin;
    if (fill_off[b] + sz >= BINB) begin
      if (b + 1 > NBINS - 1) begin
        r.status = ST_EXHAUSTED;
        return r;
      end
      b = b + 1;
      cur_bin = b;
      fill_off[b] = 0;
      ent_count[b] = 0;
    end
    n = ent_count[b];
    for (int i = 0; i < n; i++) begin
      if (!ent_used[b][i] && sz <= ent_size[b][i]) begin
        ent_used[b][i] = 1'b1;
        r.status = ST_OK;
        r.result_address = ADDR_W'(longint'(b) * BINB + ent_start[b][i]);
        return r;
      end
    end
    if (n >= NENT) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    ent_start[b][n] = fill_off[b];
    ent_size[b][n] = sz;
    ent_used[b][n] = 1'b1;
    ent_count[b] = n + 1;
    r.status = ST_OK;
    r.result_address = ADDR_W'(longint'(b) * BINB + fill_off[b]);
    fill_off[b] = fill_off[b] + sz;
    return r;
  endfunction

  // free: first used entry holding the address, bins 0 up to active
  function automatic out_item_t model_free(longint addr);
    out_item_t r;
    longint    lo;
    r = '0;
    r.status = ST_NOT_FOUND;
    for (int j = 0; j <= cur_bin; j++) begin
      for (int i = 0; i < ent_count[j]; i++) begin
        lo = longint'(j) * BINB + ent_start[j][i];
        if (ent_used[j][i] && addr >= lo && addr < lo + ent_size[j][i]) begin
          ent_used[j][i] = 1'b0;
          r.status = ST_OK;
          return r;
        end
      end
    end
    return r;
  endfunction

  // queue one request together with its expected result
  task automatic add_req(logic op, int unsigned len, int unsigned addr);
    in_item_t  it;
    out_item_t r;
    it.operation = op;
    it.length = LEN_W'(len);
    it.address = ADDR_W'(addr);
    if (op == OP_ALLOC) r = model_alloc(longint'(it.length));
    else r = model_free(longint'(it.address));
    if (op == OP_ALLOC && r.status == ST_OK) handed_out.push_back(r.result_address);
    pending_reqs.push_back(it);
    expected_results.push_back(r);
  endtask

  // free of a handed-out chunk (possibly already freed), or a wild address
  task automatic add_free();
    int unsigned a;
    if (handed_out.size() > 0 && $urandom_range(0, 9) < 8)
      a = int'(handed_out[$urandom_range(0, handed_out.size() - 1)]) + $urandom_range(0, BLK - 1);
    else
      a = $urandom;
    add_req(OP_FREE, $urandom, a);
  endtask

  // stimulus
  initial begin
    int unsigned a0;
    cur_bin = 0;
    for (int b = 0; b < NBINS; b++) begin
      fill_off[b] = 0;
      ent_count[b] = 0;
    end
    // directed: extremes, too large, bin move, double free
    add_req(OP_ALLOC, 0, 27'h7ffffff);
    add_req(OP_ALLOC, 22'h3fffff, 0);
    add_req(OP_ALLOC, 4194288, 0);
    add_req(OP_FREE, 0, 27'h7ffffff);
    add_req(OP_FREE, 22'h3fffff, 5);
    add_req(OP_FREE, 0, 5);
    add_req(OP_ALLOC, 4194287, 0);
    a0 = int'(handed_out[$]);
    add_req(OP_FREE, 0, a0 + 4194287);
    add_req(OP_FREE, 0, a0 + 4194288);
    add_req(OP_FREE, 0, a0 + 4194287);
    add_req(OP_ALLOC, 100, 0);
    add_req(OP_ALLOC, 15, 0);
    add_req(OP_FREE, 0, a0);
    add_req(OP_ALLOC, 31, 0);
    add_req(OP_ALLOC, 4194287, 0);
    // small chunks in one bin until its entry table fills up
    for (int k = 0; k < 320; k++) begin
      if ($urandom_range(0, 3) == 0) add_free();
      else add_req(OP_ALLOC, $urandom_range(0, 300), $urandom);
    end
    // large chunks: walk through the bins until they run out
    for (int k = 0; k < 220; k++) begin
      if ($urandom_range(0, 2) == 0) add_free();
      else if ($urandom_range(0, 3) == 0) add_req(OP_ALLOC, $urandom_range(0, 4000), $urandom);
      else add_req(OP_ALLOC, $urandom, $urandom);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit idle_now();
    if (cycles > NOIDLE_LO && cycles < NOIDLE_HI) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  // driver: one request transfer at a time
  always @(posedge clk) begin
    bit       busy;
    in_item_t nxt;
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && in_stall;
      if (!busy) begin
        if (pending_reqs.size() > 0 && !idle_now()) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer, toggle out_stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result transfer: status %0d addr %h",
                     out_data.status, out_data.result_address);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.result_address !== want.result_address) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                       want.status, out_data.status,
                       want.result_address, out_data.result_address);
          end
        end
      end
      out_stall <= idle_now();
      if (pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0)
        all_done <= 1'b1;
    end
    if (cycles > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (all_done);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hdl/bba_pkg.sv
hdl/bba_cmp.sv
hdl/binned_bump_allocator.sv
verif/testbench.sv
